@@ design/rgb_to_hsv_converter_macros.svh @@
// ----------------------------------------------------------------------------
// RGB to HSV converter assertion macros
// Shared concurrent assertion forms for the converter checker.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RGB2HSV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RGB2HSV_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rgb2hsv_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Shared constants, types and width helpers of the converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rgb2hsv_pkg;

  localparam int unsigned CHAN_BITS_DEFAULT = 8;
  localparam int unsigned HUE_BITS          = 11;
  localparam int unsigned HUE_FRAC_BITS     = 8;
  localparam int unsigned HUE_TURN          = 1536;
  localparam int unsigned SECTOR_BITS       = HUE_BITS - HUE_FRAC_BITS - 1;

  typedef enum logic [SECTOR_BITS-1:0] {
    SECTOR_RED   = 2'd0,
    SECTOR_GREEN = 2'd1,
    SECTOR_BLUE  = 2'd2
  } rgb2hsv_sector_e;

  // A gray pixel has zero chroma, so hue and saturation are forced to zero.
  typedef struct packed {
    rgb2hsv_sector_e sector;
    logic            neg;
    logic            gray;
  } rgb2hsv_side_t;

  // Number of quotient bits, one per divider cell.
  function automatic int unsigned quot_bits(input int unsigned cb);
    quot_bits = (cb > HUE_FRAC_BITS + 1) ? cb : HUE_FRAC_BITS + 1;
  endfunction

  // Width of the partial remainders carried along the cell row.
  function automatic int unsigned rem_bits(input int unsigned cb);
    rem_bits = cb + ((cb > HUE_FRAC_BITS) ? cb : HUE_FRAC_BITS);
  endfunction

endpackage

@@ design/rgb2hsv_rgb_if.sv @@
// ----------------------------------------------------------------------------
// RGB pixel channel
// Valid/ready channel carrying one red, green and blue pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rgb2hsv_rgb_if #(
  parameter int unsigned CHANNEL_BITS = rgb2hsv_pkg::CHAN_BITS_DEFAULT
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ design/rgb2hsv_hsv_if.sv @@
// ----------------------------------------------------------------------------
// HSV pixel channel
// Valid/ready channel carrying one hue, saturation and value result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rgb2hsv_hsv_if #(
  parameter int unsigned CHANNEL_BITS = rgb2hsv_pkg::CHAN_BITS_DEFAULT
);
  import rgb2hsv_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [HUE_BITS-1:0]     hue;
  logic [CHANNEL_BITS-1:0] saturation;
  logic [CHANNEL_BITS-1:0] value;

  modport source (output valid, output hue, output saturation, output value, input ready);
  modport sink   (input valid, input hue, input saturation, input value, output ready);
endinterface

@@ design/rgb_to_hsv_converter.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Converts a pixel stream to hue, saturation and value through a row of
// divider cells.
//
//   Channel  Direction  Payload                       Width
//   rgb_i    in         red, green, blue              CHANNEL_BITS each
//   hsv_o    out        hue, saturation, value        11, CHANNEL_BITS each
//
// One pixel is accepted per cycle while rgb_i.ready is high; each pixel passes
// through the front stage, one divider cell per quotient bit and the output
// register.
// Reset clears only the stage valid bits; no pixel is in flight afterward.
// Each stage moves on when it is empty or its successor moves, so a stalled
// output fills the row of cells before rgb_i.ready falls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_to_hsv_converter #(
  parameter int unsigned CHANNEL_BITS = rgb2hsv_pkg::CHAN_BITS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  rgb2hsv_rgb_if.sink        rgb_i,
  rgb2hsv_hsv_if.source      hsv_o
);
  import rgb2hsv_pkg::*;

  localparam int unsigned QB = quot_bits(CHANNEL_BITS);
  localparam int unsigned RW = rem_bits(CHANNEL_BITS);

  logic                    valid [QB+1];
  logic                    en    [QB+1];
  logic [RW-1:0]           rem_sat [QB+1];
  logic [RW-1:0]           rem_hue [QB+1];
  logic [CHANNEL_BITS-1:0] den_sat [QB+1];
  logic [CHANNEL_BITS-1:0] den_hue [QB+1];
  logic [QB-1:0]           q_sat   [QB+1];
  logic [QB-1:0]           q_hue   [QB+1];
  rgb2hsv_side_t           side    [QB+1];

  logic                    en_out;
  logic                    out_valid_q;
  logic [HUE_BITS-1:0]     hue_q, hue_d;
  logic [CHANNEL_BITS-1:0] sat_q, val_q;
  logic [HUE_FRAC_BITS:0]  mag;
  logic [HUE_BITS:0]       frac, base, hsum;

  assign en_out = !out_valid_q || hsv_o.ready;
  assign en[QB] = !valid[QB] || en_out;

  for (genvar k = 0; k < QB; k++) begin : g_en
    assign en[k] = !valid[k] || en[k+1];
  end

  assign rgb_i.ready = en[0];
  assign q_sat[0]    = '0;
  assign q_hue[0]    = '0;

  rgb2hsv_prep #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .REM_BITS     (RW)
  ) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en[0]),
    .valid_i   (rgb_i.valid),
    .red_i     (rgb_i.red),
    .green_i   (rgb_i.green),
    .blue_i    (rgb_i.blue),
    .valid_o   (valid[0]),
    .rem_sat_o (rem_sat[0]),
    .den_sat_o (den_sat[0]),
    .rem_hue_o (rem_hue[0]),
    .den_hue_o (den_hue[0]),
    .side_o    (side[0])
  );

  for (genvar k = 0; k < QB; k++) begin : g_cell
    rgb2hsv_cell #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .REM_BITS     (RW),
      .QUOT_BITS    (QB),
      .SHIFT        (QB - 1 - k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en[k+1]),
      .valid_i   (valid[k]),
      .rem_sat_i (rem_sat[k]),
      .den_sat_i (den_sat[k]),
      .q_sat_i   (q_sat[k]),
      .rem_hue_i (rem_hue[k]),
      .den_hue_i (den_hue[k]),
      .q_hue_i   (q_hue[k]),
      .side_i    (side[k]),
      .valid_o   (valid[k+1]),
      .rem_sat_o (rem_sat[k+1]),
      .den_sat_o (den_sat[k+1]),
      .q_sat_o   (q_sat[k+1]),
      .rem_hue_o (rem_hue[k+1]),
      .den_hue_o (den_hue[k+1]),
      .q_hue_o   (q_hue[k+1]),
      .side_o    (side[k+1])
    );
  end

  // A negative difference rounds the hue offset toward minus infinity.
  always_comb begin
    mag  = q_hue[QB][HUE_FRAC_BITS:0]
         + (HUE_FRAC_BITS+1)'(side[QB].neg && (rem_hue[QB] != '0));
    frac = side[QB].neg ? -(HUE_BITS+1)'(mag) : (HUE_BITS+1)'(mag);
    base = (HUE_BITS+1)'({side[QB].sector, {(HUE_FRAC_BITS+1){1'b0}}});
    hsum = base + frac;
    if (hsum[HUE_BITS]) begin
      hsum = hsum + (HUE_BITS+1)'(HUE_TURN);
    end
    hue_d = side[QB].gray ? '0 : hsum[HUE_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_out) begin
      out_valid_q <= valid[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      hue_q <= hue_d;
      sat_q <= side[QB].gray ? '0 : q_sat[QB][CHANNEL_BITS-1:0];
      val_q <= den_sat[QB];
    end
  end

  assign hsv_o.valid      = out_valid_q;
  assign hsv_o.hue        = hue_q;
  assign hsv_o.saturation = sat_q;
  assign hsv_o.value      = val_q;

endmodule

@@ design/rgb2hsv_prep.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV front stage
// Finds max, min and chroma, picks the hue sector and forms both dividends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb2hsv_prep #(
  parameter int unsigned CHANNEL_BITS = rgb2hsv_pkg::CHAN_BITS_DEFAULT,
  parameter int unsigned REM_BITS     = rgb2hsv_pkg::rem_bits(CHANNEL_BITS)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [CHANNEL_BITS-1:0]   red_i,
  input  logic [CHANNEL_BITS-1:0]   green_i,
  input  logic [CHANNEL_BITS-1:0]   blue_i,
  output logic                      valid_o,
  output logic [REM_BITS-1:0]       rem_sat_o,
  output logic [CHANNEL_BITS-1:0]   den_sat_o,
  output logic [REM_BITS-1:0]       rem_hue_o,
  output logic [CHANNEL_BITS-1:0]   den_hue_o,
  output rgb2hsv_pkg::rgb2hsv_side_t side_o
);
  import rgb2hsv_pkg::*;

  logic [CHANNEL_BITS-1:0] mx, mn, chroma, abs_d;
  logic [CHANNEL_BITS:0]   diff;
  rgb2hsv_side_t           side_d;
  logic [REM_BITS-1:0]     rem_sat_d, rem_hue_d;
  logic                    valid_q;
  logic [REM_BITS-1:0]     rem_sat_q, rem_hue_q;
  logic [CHANNEL_BITS-1:0] den_sat_q, den_hue_q;
  rgb2hsv_side_t           side_q;

  always_comb begin
    mx = (red_i > green_i) ? red_i : green_i;
    mn = (red_i < green_i) ? red_i : green_i;
    if (blue_i > mx) begin
      mx = blue_i;
    end
    if (blue_i < mn) begin
      mn = blue_i;
    end
    chroma = mx - mn;

    priority if (red_i == mx) begin
      side_d.sector = SECTOR_RED;
      diff = {1'b0, green_i} - {1'b0, blue_i};
    end else if (green_i == mx) begin
      side_d.sector = SECTOR_GREEN;
      diff = {1'b0, blue_i} - {1'b0, red_i};
    end else begin
      side_d.sector = SECTOR_BLUE;
      diff = {1'b0, red_i} - {1'b0, green_i};
    end
    side_d.neg  = diff[CHANNEL_BITS];
    side_d.gray = (chroma == '0);
    abs_d = side_d.neg ? CHANNEL_BITS'(-diff) : diff[CHANNEL_BITS-1:0];

    rem_sat_d = REM_BITS'({chroma, {CHANNEL_BITS{1'b0}}}) - REM_BITS'(chroma);
    rem_hue_d = REM_BITS'({abs_d, {HUE_FRAC_BITS{1'b0}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_sat_q <= rem_sat_d;
      den_sat_q <= mx;
      rem_hue_q <= rem_hue_d;
      den_hue_q <= chroma;
      side_q    <= side_d;
    end
  end

  assign valid_o   = valid_q;
  assign rem_sat_o = rem_sat_q;
  assign den_sat_o = den_sat_q;
  assign rem_hue_o = rem_hue_q;
  assign den_hue_o = den_hue_q;
  assign side_o    = side_q;

endmodule

@@ design/rgb2hsv_cell.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV divider cell
// One restoring step for both the saturation and the hue division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb2hsv_cell #(
  parameter int unsigned CHANNEL_BITS = rgb2hsv_pkg::CHAN_BITS_DEFAULT,
  parameter int unsigned REM_BITS     = rgb2hsv_pkg::rem_bits(CHANNEL_BITS),
  parameter int unsigned QUOT_BITS    = rgb2hsv_pkg::quot_bits(CHANNEL_BITS),
  parameter int unsigned SHIFT        = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [REM_BITS-1:0]       rem_sat_i,
  input  logic [CHANNEL_BITS-1:0]   den_sat_i,
  input  logic [QUOT_BITS-1:0]      q_sat_i,
  input  logic [REM_BITS-1:0]       rem_hue_i,
  input  logic [CHANNEL_BITS-1:0]   den_hue_i,
  input  logic [QUOT_BITS-1:0]      q_hue_i,
  input  rgb2hsv_pkg::rgb2hsv_side_t side_i,
  output logic                      valid_o,
  output logic [REM_BITS-1:0]       rem_sat_o,
  output logic [CHANNEL_BITS-1:0]   den_sat_o,
  output logic [QUOT_BITS-1:0]      q_sat_o,
  output logic [REM_BITS-1:0]       rem_hue_o,
  output logic [CHANNEL_BITS-1:0]   den_hue_o,
  output logic [QUOT_BITS-1:0]      q_hue_o,
  output rgb2hsv_pkg::rgb2hsv_side_t side_o
);
  import rgb2hsv_pkg::*;

  logic [REM_BITS-1:0]     sub_sat, sub_hue;
  logic                    take_sat, take_hue;
  logic                    valid_q;
  logic [REM_BITS-1:0]     rem_sat_q, rem_hue_q;
  logic [CHANNEL_BITS-1:0] den_sat_q, den_hue_q;
  logic [QUOT_BITS-1:0]    q_sat_q, q_hue_q;
  rgb2hsv_side_t           side_q;

  assign sub_sat  = REM_BITS'(den_sat_i) << SHIFT;
  assign sub_hue  = REM_BITS'(den_hue_i) << SHIFT;
  assign take_sat = (rem_sat_i >= sub_sat);
  assign take_hue = (rem_hue_i >= sub_hue);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_sat_q <= take_sat ? (rem_sat_i - sub_sat) : rem_sat_i;
      rem_hue_q <= take_hue ? (rem_hue_i - sub_hue) : rem_hue_i;
      q_sat_q   <= q_sat_i | (QUOT_BITS'(take_sat) << SHIFT);
      q_hue_q   <= q_hue_i | (QUOT_BITS'(take_hue) << SHIFT);
      den_sat_q <= den_sat_i;
      den_hue_q <= den_hue_i;
      side_q    <= side_i;
    end
  end

  assign valid_o   = valid_q;
  assign rem_sat_o = rem_sat_q;
  assign den_sat_o = den_sat_q;
  assign q_sat_o   = q_sat_q;
  assign rem_hue_o = rem_hue_q;
  assign den_hue_o = den_hue_q;
  assign q_hue_o   = q_hue_q;
  assign side_o    = side_q;

endmodule

@@ design/rgb2hsv_chk.sv @@
// ----------------------------------------------------------------------------
// RGB to HSV converter checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rgb_to_hsv_converter_macros.svh"

module rgb2hsv_chk #(
  parameter int unsigned CHANNEL_BITS = rgb2hsv_pkg::CHAN_BITS_DEFAULT
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [rgb2hsv_pkg::HUE_BITS-1:0] hue_i,
  input logic [CHANNEL_BITS-1:0]          saturation_i,
  input logic [CHANNEL_BITS-1:0]          value_i
);
  import rgb2hsv_pkg::*;

  `RGB2HSV_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(hue_i) && $stable(saturation_i) && $stable(value_i), "Stalled result transaction changed.")
  `RGB2HSV_ASSERT_IMP(a_hue_range, clk_i, rst_ni, out_valid_i, hue_i < HUE_BITS'(HUE_TURN), "Hue is outside one turn.")
  `RGB2HSV_ASSERT_IMP(a_black_gray, clk_i, rst_ni, out_valid_i && (value_i == '0), (saturation_i == '0) && (hue_i == '0), "Black pixel has nonzero hue or saturation.")
  `RGB2HSV_ASSERT_IMP(a_gray_hue, clk_i, rst_ni, out_valid_i && (saturation_i == '0), hue_i == '0, "Unsaturated pixel has nonzero hue.")

endmodule

bind rgb_to_hsv_converter rgb2hsv_chk #(
  .CHANNEL_BITS (CHANNEL_BITS)
) u_rgb2hsv_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (hsv_o.valid),
  .out_ready_i  (hsv_o.ready),
  .hue_i        (hsv_o.hue),
  .saturation_i (hsv_o.saturation),
  .value_i      (hsv_o.value)
);
